@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define HFI_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that also holds through reset.
`define HFI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/hfi_pkg.sv @@
// Types, constants, cosine table function and microcode program of the HFI demodulator.
package hfi_pkg;

    localparam int DATA_W         = 16;
    localparam int FRAC_BITS      = 15;
    localparam int GAIN_FRAC      = 12;
    localparam int COEF_W         = 15;
    localparam int PHASE_W        = 16;
    localparam int COS_TABLE_BITS = 10;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int MUL_W          = 17;
    localparam int PROD_W         = 34;
    localparam int STEP_W         = 4;

    typedef logic signed [DATA_W-1:0]  data_t;
    typedef logic signed [MUL_W-1:0]   oper_t;
    typedef logic signed [PROD_W-1:0]  wide_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
    typedef logic [STEP_W-1:0]         step_t;

    // register indexes
    localparam cfg_idx_t REG_PHASE_STEP     = 3'd0;
    localparam cfg_idx_t REG_INJ_AMPLITUDE  = 3'd1;
    localparam cfg_idx_t REG_HIGHPASS_ALPHA = 3'd2;
    localparam cfg_idx_t REG_DEMOD_ALPHA    = 3'd3;
    localparam cfg_idx_t REG_MIN_RESPONSE   = 3'd4;
    localparam cfg_idx_t REG_DEMOD_GAIN     = 3'd5;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_step;
        logic [COEF_W-1:0]  injection_amplitude;
        logic [COEF_W-1:0]  highpass_alpha;
        logic [COEF_W-1:0]  demod_alpha;
        logic [COEF_W-1:0]  minimum_response;
        logic [PHASE_W-1:0] demod_gain;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        phase_step:          16'd1024,
        injection_amplitude: 15'd3277,
        highpass_alpha:      15'd29491,
        demod_alpha:         15'd3277,
        minimum_response:    15'd328,
        demod_gain:          16'd4096
    };

    typedef enum logic [2:0] {
        OP_NOP, OP_ADD, OP_SUB, OP_MUL15, OP_MUL12
    } op_t;

    typedef enum logic [3:0] {
        SRC_ZERO, SRC_X, SRC_LAST_CUR, SRC_LAST_CAR, SRC_CARRIER, SRC_HP, SRC_DEMOD,
        SRC_TMP, SRC_HP_ALPHA, SRC_DM_ALPHA, SRC_AMP, SRC_GAIN
    } src_t;

    typedef enum logic [2:0] {
        DST_NONE, DST_TMP, DST_HP, DST_DEMOD, DST_INJ
    } dst_t;

    typedef enum logic [1:0] {
        JMP_NEXT, JMP_WAIT_IN, JMP_NOT_SEEN, JMP_WAIT_OUT
    } jmp_t;

    typedef struct packed {
        op_t   op;
        src_t  src_a;
        src_t  src_b;
        dst_t  dst;
        jmp_t  jmp;
        logic  commit;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic seen;
        logic out_busy;
    } status_t;

    // program steps
    localparam step_t STEP_IDLE   = 4'd0;
    localparam step_t STEP_DIFF   = 4'd1;
    localparam step_t STEP_HP_SUM = 4'd2;
    localparam step_t STEP_HP_MUL = 4'd3;
    localparam step_t STEP_INJ    = 4'd4;
    localparam step_t STEP_PROD   = 4'd5;
    localparam step_t STEP_GAIN   = 4'd6;
    localparam step_t STEP_ERR    = 4'd7;
    localparam step_t STEP_LP_MUL = 4'd8;
    localparam step_t STEP_LP_ADD = 4'd9;
    localparam step_t STEP_COMMIT = 4'd10;

    localparam wide_t SAT_HI = PROD_W'(2**FRAC_BITS - 1);
    localparam wide_t SAT_LO = PROD_W'(-(2**FRAC_BITS));

    function automatic data_t sat(input wide_t v);
        data_t r;
        if (v > SAT_HI) begin
            r = data_t'(SAT_HI[DATA_W-1:0]);
        end else if (v < SAT_LO) begin
            r = data_t'(SAT_LO[DATA_W-1:0]);
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // cosine entry k of a 2^tbits table, quarter wave by Taylor series in Q30
    function automatic data_t cos_entry(input int unsigned k, input int unsigned tbits);
        logic [63:0] p;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] tu;
        logic [63:0] mag;
        logic [1:0]  quad;
        longint      t;
        data_t       res;
        p    = 64'(k) << (PHASE_W - tbits);
        quad = p[15:14];
        r    = 64'(p[13:0]);
        if (quad[0]) begin
            r = 64'd16384 - r;
        end
        x  = (r * 64'd1686629713) >> 14;
        x2 = (x * x) >> 30;
        t  = 64'sd1073741824 - longint'(x2 / 64'd56);
        tu = 64'(t);
        t  = 64'sd1073741824 - longint'(((x2 * tu) >> 30) / 64'd30);
        tu = 64'(t);
        t  = 64'sd1073741824 - longint'(((x2 * tu) >> 30) / 64'd12);
        tu = 64'(t);
        t  = 64'sd1073741824 - longint'(((x2 * tu) >> 30) / 64'd2);
        if (t < 0) begin
            t = 0;
        end
        tu  = 64'(t);
        mag = ((tu << FRAC_BITS) + (64'd1 << 29)) >> 30;
        if (mag > 64'(2**FRAC_BITS - 1)) begin
            mag = 64'(2**FRAC_BITS - 1);
        end
        res = data_t'(mag[DATA_W-1:0]);
        if (quad == 2'd1 || quad == 2'd2) begin
            res = -res;
        end
        return res;
    endfunction

    function automatic ctrl_t mk(input op_t op, input src_t a, input src_t b, input dst_t d,
                                 input jmp_t j, input logic c, input step_t tgt);
        ctrl_t w;
        w.op     = op;
        w.src_a  = a;
        w.src_b  = b;
        w.dst    = d;
        w.jmp    = j;
        w.commit = c;
        w.target = tgt;
        return w;
    endfunction

    // control store
    function automatic ctrl_t ucode(input step_t s);
        ctrl_t w;
        unique case (s)
            STEP_IDLE:   w = mk(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, JMP_WAIT_IN, 1'b0, STEP_IDLE);
            STEP_DIFF:   w = mk(OP_SUB, SRC_X, SRC_LAST_CUR, DST_TMP, JMP_NEXT, 1'b0, STEP_IDLE);
            STEP_HP_SUM: w = mk(OP_ADD, SRC_HP, SRC_TMP, DST_TMP, JMP_NEXT, 1'b0, STEP_IDLE);
            STEP_HP_MUL: w = mk(OP_MUL15, SRC_HP_ALPHA, SRC_TMP, DST_HP, JMP_NEXT, 1'b0,
                                STEP_IDLE);
            // no earlier carrier: skip the demodulator
            STEP_INJ:    w = mk(OP_MUL15, SRC_AMP, SRC_CARRIER, DST_INJ, JMP_NOT_SEEN, 1'b0,
                                STEP_COMMIT);
            STEP_PROD:   w = mk(OP_MUL15, SRC_HP, SRC_LAST_CAR, DST_TMP, JMP_NEXT, 1'b0,
                                STEP_IDLE);
            STEP_GAIN:   w = mk(OP_MUL12, SRC_GAIN, SRC_TMP, DST_TMP, JMP_NEXT, 1'b0, STEP_IDLE);
            STEP_ERR:    w = mk(OP_SUB, SRC_TMP, SRC_DEMOD, DST_TMP, JMP_NEXT, 1'b0, STEP_IDLE);
            STEP_LP_MUL: w = mk(OP_MUL15, SRC_DM_ALPHA, SRC_TMP, DST_TMP, JMP_NEXT, 1'b0,
                                STEP_IDLE);
            STEP_LP_ADD: w = mk(OP_ADD, SRC_DEMOD, SRC_TMP, DST_DEMOD, JMP_NEXT, 1'b0, STEP_IDLE);
            STEP_COMMIT: w = mk(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, JMP_WAIT_OUT, 1'b1,
                                STEP_IDLE);
            default:     w = mk(OP_NOP, SRC_ZERO, SRC_ZERO, DST_NONE, JMP_WAIT_OUT, 1'b0,
                                STEP_IDLE);
        endcase
        return w;
    endfunction

endpackage

@@ hw/rtl/hfi_cfg.sv @@
// Configuration register file of the HFI demodulator.
module hfi_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  hfi_pkg::cfg_idx_t               cfg_index,
    input  logic [hfi_pkg::CFG_DATA_W-1:0]  cfg_data,
    output hfi_pkg::cfg_t                   cfg
);

    hfi_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= hfi_pkg::CFG_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                hfi_pkg::REG_PHASE_STEP:     cfg_reg.phase_step <= cfg_data;
                hfi_pkg::REG_INJ_AMPLITUDE:
                    cfg_reg.injection_amplitude <= cfg_data[hfi_pkg::COEF_W-1:0];
                hfi_pkg::REG_HIGHPASS_ALPHA:
                    cfg_reg.highpass_alpha <= cfg_data[hfi_pkg::COEF_W-1:0];
                hfi_pkg::REG_DEMOD_ALPHA:
                    cfg_reg.demod_alpha <= cfg_data[hfi_pkg::COEF_W-1:0];
                hfi_pkg::REG_MIN_RESPONSE:
                    cfg_reg.minimum_response <= cfg_data[hfi_pkg::COEF_W-1:0];
                hfi_pkg::REG_DEMOD_GAIN:     cfg_reg.demod_gain <= cfg_data;
                default: begin
                    // unmapped index: word dropped
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/hfi_useq.sv @@
// Microcode sequencer: step counter, control store lookup and jumps.
module hfi_useq (
    input  logic             aclk,
    input  logic             aresetn,
    input  hfi_pkg::status_t status,
    output hfi_pkg::ctrl_t   ctrl
);

    hfi_pkg::step_t step_reg;
    hfi_pkg::step_t step_next;
    hfi_pkg::step_t step_inc;

    assign ctrl     = hfi_pkg::ucode(step_reg);
    assign step_inc = step_reg + hfi_pkg::step_t'(1);

    always_comb begin
        unique case (ctrl.jmp)
            hfi_pkg::JMP_NEXT:     step_next = step_inc;
            hfi_pkg::JMP_WAIT_IN:  step_next = status.in_valid ? step_inc : step_reg;
            hfi_pkg::JMP_NOT_SEEN: step_next = status.seen ? step_inc : ctrl.target;
            hfi_pkg::JMP_WAIT_OUT: step_next = status.out_busy ? step_reg : ctrl.target;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= hfi_pkg::STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

@@ hw/rtl/hfi_dpath.sv @@
// Datapath: filter state, shared multiply/add unit, cosine ROM and output register.
module hfi_dpath #(
    parameter int COS_TABLE_BITS = hfi_pkg::COS_TABLE_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  hfi_pkg::ctrl_t               ctrl,
    input  hfi_pkg::cfg_t                cfg,
    input  logic                         in_fire,
    input  hfi_pkg::data_t               current_d,
    input  logic                         m_tready,
    output logic                         seen,
    output logic                         out_busy,
    output logic                         m_tvalid,
    output hfi_pkg::data_t               injection_d,
    output hfi_pkg::data_t               position_error,
    output logic [hfi_pkg::COEF_W-1:0]   response,
    output logic                         estimate_valid
);

    localparam int COS_DEPTH = 2**COS_TABLE_BITS;

    hfi_pkg::data_t cos_rom [COS_DEPTH];

    for (genvar g = 0; g < COS_DEPTH; g++) begin : g_cos
        assign cos_rom[g] = hfi_pkg::cos_entry(g, COS_TABLE_BITS);
    end

    logic [hfi_pkg::PHASE_W-1:0] phase_reg;
    hfi_pkg::data_t              carrier_reg;
    hfi_pkg::data_t              x_reg;
    hfi_pkg::data_t              last_cur_reg;
    hfi_pkg::data_t              last_car_reg;
    hfi_pkg::data_t              hp_reg;
    hfi_pkg::data_t              demod_reg;
    hfi_pkg::data_t              tmp_reg;
    hfi_pkg::data_t              inj_reg;
    logic                        seen_reg;
    logic                        out_valid_reg;
    hfi_pkg::data_t              out_inj_reg;
    hfi_pkg::data_t              out_err_reg;
    logic [hfi_pkg::COEF_W-1:0]  out_resp_reg;
    logic                        out_est_reg;

    hfi_pkg::oper_t              opa;
    hfi_pkg::oper_t              opb;
    hfi_pkg::wide_t              prod_w;
    hfi_pkg::wide_t              sum_w;
    hfi_pkg::data_t              alu_res;
    hfi_pkg::data_t              abs_w;
    logic [hfi_pkg::COEF_W-1:0]  resp_w;
    logic                        est_w;
    logic                        commit_go;

    always_comb begin
        unique case (ctrl.src_a)
            hfi_pkg::SRC_X:        opa = hfi_pkg::MUL_W'(x_reg);
            hfi_pkg::SRC_LAST_CUR: opa = hfi_pkg::MUL_W'(last_cur_reg);
            hfi_pkg::SRC_LAST_CAR: opa = hfi_pkg::MUL_W'(last_car_reg);
            hfi_pkg::SRC_CARRIER:  opa = hfi_pkg::MUL_W'(carrier_reg);
            hfi_pkg::SRC_HP:       opa = hfi_pkg::MUL_W'(hp_reg);
            hfi_pkg::SRC_DEMOD:    opa = hfi_pkg::MUL_W'(demod_reg);
            hfi_pkg::SRC_TMP:      opa = hfi_pkg::MUL_W'(tmp_reg);
            hfi_pkg::SRC_HP_ALPHA: opa = hfi_pkg::MUL_W'(cfg.highpass_alpha);
            hfi_pkg::SRC_DM_ALPHA: opa = hfi_pkg::MUL_W'(cfg.demod_alpha);
            hfi_pkg::SRC_AMP:      opa = hfi_pkg::MUL_W'(cfg.injection_amplitude);
            hfi_pkg::SRC_GAIN:     opa = hfi_pkg::MUL_W'(cfg.demod_gain);
            default:               opa = '0;
        endcase
    end

    always_comb begin
        unique case (ctrl.src_b)
            hfi_pkg::SRC_X:        opb = hfi_pkg::MUL_W'(x_reg);
            hfi_pkg::SRC_LAST_CUR: opb = hfi_pkg::MUL_W'(last_cur_reg);
            hfi_pkg::SRC_LAST_CAR: opb = hfi_pkg::MUL_W'(last_car_reg);
            hfi_pkg::SRC_CARRIER:  opb = hfi_pkg::MUL_W'(carrier_reg);
            hfi_pkg::SRC_HP:       opb = hfi_pkg::MUL_W'(hp_reg);
            hfi_pkg::SRC_DEMOD:    opb = hfi_pkg::MUL_W'(demod_reg);
            hfi_pkg::SRC_TMP:      opb = hfi_pkg::MUL_W'(tmp_reg);
            hfi_pkg::SRC_HP_ALPHA: opb = hfi_pkg::MUL_W'(cfg.highpass_alpha);
            hfi_pkg::SRC_DM_ALPHA: opb = hfi_pkg::MUL_W'(cfg.demod_alpha);
            hfi_pkg::SRC_AMP:      opb = hfi_pkg::MUL_W'(cfg.injection_amplitude);
            hfi_pkg::SRC_GAIN:     opb = hfi_pkg::MUL_W'(cfg.demod_gain);
            default:               opb = '0;
        endcase
    end

    // coefficients are zero-extended, so they stay positive in the signed product
    assign prod_w = hfi_pkg::PROD_W'(opa) * hfi_pkg::PROD_W'(opb);

    always_comb begin
        unique case (ctrl.op)
            hfi_pkg::OP_SUB: sum_w = hfi_pkg::PROD_W'(opa) - hfi_pkg::PROD_W'(opb);
            default:         sum_w = hfi_pkg::PROD_W'(opa) + hfi_pkg::PROD_W'(opb);
        endcase
    end

    always_comb begin
        unique case (ctrl.op)
            hfi_pkg::OP_ADD,
            hfi_pkg::OP_SUB:   alu_res = hfi_pkg::sat(sum_w);
            hfi_pkg::OP_MUL15: alu_res = hfi_pkg::sat(prod_w >>> hfi_pkg::FRAC_BITS);
            hfi_pkg::OP_MUL12: alu_res = hfi_pkg::sat(prod_w >>> hfi_pkg::GAIN_FRAC);
            default:           alu_res = '0;
        endcase
    end

    // most negative value folds to the positive maximum
    assign abs_w  = hfi_pkg::sat(-hfi_pkg::PROD_W'(demod_reg));
    assign resp_w = demod_reg[hfi_pkg::DATA_W-1] ? abs_w[hfi_pkg::COEF_W-1:0]
                                                 : demod_reg[hfi_pkg::COEF_W-1:0];
    assign est_w  = seen_reg && (resp_w >= cfg.minimum_response);

    assign out_busy  = out_valid_reg && !m_tready;
    assign commit_go = ctrl.commit && !out_busy;

    always_ff @(posedge aclk) begin
        carrier_reg <= cos_rom[phase_reg[hfi_pkg::PHASE_W-1 -: COS_TABLE_BITS]];
        if (in_fire) begin
            x_reg <= current_d;
        end
        if (ctrl.dst == hfi_pkg::DST_TMP) begin
            tmp_reg <= alu_res;
        end
        if (ctrl.dst == hfi_pkg::DST_INJ) begin
            inj_reg <= alu_res;
        end
        if (commit_go) begin
            out_inj_reg  <= inj_reg;
            out_err_reg  <= demod_reg;
            out_resp_reg <= resp_w;
            out_est_reg  <= est_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= '0;
            last_cur_reg  <= '0;
            last_car_reg  <= '0;
            hp_reg        <= '0;
            demod_reg     <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ctrl.dst == hfi_pkg::DST_HP) begin
                hp_reg <= alu_res;
            end
            if (ctrl.dst == hfi_pkg::DST_DEMOD) begin
                demod_reg <= alu_res;
            end
            if (commit_go) begin
                last_cur_reg <= x_reg;
                last_car_reg <= carrier_reg;
                seen_reg     <= 1'b1;
                phase_reg    <= phase_reg + cfg.phase_step;
            end
            out_valid_reg <= commit_go || (out_valid_reg && !m_tready);
        end
    end

    assign seen           = seen_reg;
    assign m_tvalid       = out_valid_reg;
    assign injection_d    = out_inj_reg;
    assign position_error = out_err_reg;
    assign response       = out_resp_reg;
    assign estimate_valid = out_est_reg;

endmodule

@@ hw/rtl/hfi_injection_demodulator_top.sv @@
// An input word is taken at the idle step; the single multiply/add unit then walks the
// high-pass, injection and demodulator steps, one operation per step, skipping the
// demodulator with no earlier carrier; the next word is taken only after the commit step.
// A result waiting at the output does not block the next input word.
// Reset (aresetn low, synchronous): registers to defaults, phase and filters cleared.
module hfi_injection_demodulator_top #(
    parameter int COS_TABLE_BITS = hfi_pkg::COS_TABLE_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [15:0] current_d
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata,   // [15:0] injection_d,
                                                       // [31:16] position_error,
                                                       // [46:32] response, [47] zero
    output logic                            m_tuser,   // [0] estimate_valid
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  hfi_pkg::cfg_idx_t               cfg_index,
    input  logic [hfi_pkg::CFG_DATA_W-1:0]  cfg_data
);

    hfi_pkg::cfg_t              cfg;
    hfi_pkg::ctrl_t             ctrl;
    hfi_pkg::status_t           status;
    logic                       in_fire;
    logic                       seen;
    logic                       out_busy;
    hfi_pkg::data_t             injection_d;
    hfi_pkg::data_t             position_error;
    logic [hfi_pkg::COEF_W-1:0] response;
    logic                       estimate_valid;

    assign s_tready = (ctrl.jmp == hfi_pkg::JMP_WAIT_IN);
    assign in_fire  = s_tvalid && s_tready;

    assign status.in_valid = s_tvalid;
    assign status.seen     = seen;
    assign status.out_busy = out_busy;

    hfi_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hfi_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    hfi_dpath #(
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .cfg            (cfg),
        .in_fire        (in_fire),
        .current_d      (s_tdata),
        .m_tready       (m_tready),
        .seen           (seen),
        .out_busy       (out_busy),
        .m_tvalid       (m_tvalid),
        .injection_d    (injection_d),
        .position_error (position_error),
        .response       (response),
        .estimate_valid (estimate_valid)
    );

    assign m_tdata = {1'b0, response, position_error, injection_d};
    assign m_tuser = estimate_valid;

endmodule

@@ hw/rtl/hfi_checker.sv @@
// Port-level checker for the HFI demodulator, bound to the top level.
`include "assert_macros.svh"

module hfi_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [47:0]                     m_tdata,
    input logic                            m_tuser
);

    logic        in_acc;
    logic        out_stall;
    logic        out_pos;
    logic        resp_match;
    logic [49:0] out_bus;

    assign in_acc     = s_tvalid && s_tready;
    assign out_stall  = m_tvalid && !m_tready;
    assign out_pos    = m_tvalid && !m_tdata[31];
    assign resp_match = (m_tdata[46:32] == m_tdata[30:16]);
    assign out_bus    = {m_tvalid, m_tuser, m_tdata};

    // output word empty straight after reset
    `HFI_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
    // stalled output word stays put
    `HFI_ASSERT(a_out_hold, aclk, aresetn, out_stall |=> $stable(out_bus), "stalled word changed")
    // a new word is taken only once the program is back at its idle step
    `HFI_ASSERT(a_in_gap, aclk, aresetn, in_acc |=> !s_tready [*3], "input taken mid-program")
    // response equals position error when it is non-negative
    `HFI_ASSERT(a_resp_abs, aclk, aresetn, out_pos |-> resp_match, "response mismatch")

endmodule

bind hfi_injection_demodulator_top hfi_checker u_hfi_checker (.*);

@@ verif/tb_hfi_injection_demodulator_top.sv @@
// Self-checking testbench for the HFI demodulator: a directed table, then random phases.
`timescale 1ns / 100ps

module tb_hfi_injection_demodulator_top;

    localparam hfi_pkg::cfg_idx_t REG_SPARE_A = 3'd6;
    localparam hfi_pkg::cfg_idx_t REG_SPARE_B = 3'd7;
    localparam int TABLE_SHIFT  = hfi_pkg::PHASE_W - hfi_pkg::COS_TABLE_BITS;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 115;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [15:0] injection;
        logic [15:0] pos_error;
        logic [14:0] response;
        logic        est_valid;
    } estimate_t;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        hfi_pkg::cfg_idx_t  idx;
        logic [15:0]        value;
        bit                 typed;
        estimate_t          want;
    } plan_row_t;

    logic                      aclk;
    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [15:0]               s_tdata   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [47:0]               m_tdata;
    logic                      m_tuser;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    hfi_pkg::cfg_idx_t         cfg_index = '0;
    logic [15:0]               cfg_data  = '0;

    // observer state and register copy
    longint      ph_step  = 1024;
    longint      amp      = 3277;
    longint      hp_alpha = 29491;
    longint      dm_alpha = 3277;
    longint      min_resp = 328;
    longint      gain     = 4096;
    logic [15:0] phase    = '0;
    longint      prev_cur = 0;
    longint      prev_car = 0;
    longint      hp_val   = 0;
    longint      dm_val   = 0;
    bit          seen     = 1'b0;

    estimate_t   estimate_q[$];
    int          errors   = 0;
    int          samples  = 0;
    int          results  = 0;
    int          writes   = 0;
    bit          quiet    = 1'b0;
    bit          cfg_open = 1'b0;
    int          stall_left = 0;

    hfi_injection_demodulator_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic longint clamp_q15(input longint v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    // arithmetic shift gives the floor rounding
    function automatic longint q15_mul(input longint a, input longint b);
        return clamp_q15((a * b) >>> 15);
    endfunction

    // carrier from the top table bits of the phase: quadrant fold, Taylor series in Q30
    function automatic longint carrier_at(input logic [15:0] ph);
        longint unsigned pt;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned tu;
        longint          t;
        longint          mag;
        logic [1:0]      quad;
        pt   = (64'(ph) >> TABLE_SHIFT) << TABLE_SHIFT;
        quad = pt[15:14];
        r    = pt & 64'h3FFF;
        if (quad[0]) begin
            r = 64'd16384 - r;
        end
        x  = (r * 64'd1686629713) >> 14;
        x2 = (x * x) >> 30;
        t  = 64'sd1073741824 - $signed(x2 / 64'd56);
        tu = $unsigned(t);
        t  = 64'sd1073741824 - $signed(((x2 * tu) >> 30) / 64'd30);
        tu = $unsigned(t);
        t  = 64'sd1073741824 - $signed(((x2 * tu) >> 30) / 64'd12);
        tu = $unsigned(t);
        t  = 64'sd1073741824 - $signed(((x2 * tu) >> 30) / 64'd2);
        if (t < 0) begin
            t = 0;
        end
        tu  = $unsigned(t);
        mag = $signed(((tu << 15) + (64'd1 << 29)) >> 30);
        if (mag > 32767) begin
            mag = 32767;
        end
        return (quad == 2'd1 || quad == 2'd2) ? -mag : mag;
    endfunction

    // one current sample through high-pass, demodulator and low-pass
    function automatic estimate_t demodulate(input logic [15:0] cur);
        longint    x;
        longint    car;
        longint    hp_in;
        longint    prod;
        longint    dm_in;
        longint    resp;
        estimate_t e;
        x     = longint'($signed(cur));
        car   = carrier_at(phase);
        hp_in = clamp_q15(hp_val + clamp_q15(x - prev_cur));
        hp_val = q15_mul(hp_alpha, hp_in);
        if (seen) begin
            prod   = q15_mul(hp_val, prev_car);
            dm_in  = clamp_q15((gain * prod) >>> 12);
            dm_val = clamp_q15(dm_val + q15_mul(dm_alpha, clamp_q15(dm_in - dm_val)));
        end
        prev_cur    = x;
        resp        = (dm_val < 0) ? clamp_q15(-dm_val) : dm_val;
        e.injection = 16'(q15_mul(amp, car));
        e.pos_error = 16'(dm_val);
        e.response  = 15'(resp);
        e.est_valid = seen && (resp >= min_resp);
        prev_car    = car;
        seen        = 1'b1;
        phase       = phase + 16'(ph_step);
        return e;
    endfunction

    function automatic void apply_reg(input hfi_pkg::cfg_idx_t idx, input logic [15:0] val);
        case (idx)
            hfi_pkg::REG_PHASE_STEP:     ph_step  = longint'(val);
            hfi_pkg::REG_INJ_AMPLITUDE:  amp      = longint'(val[14:0]);
            hfi_pkg::REG_HIGHPASS_ALPHA: hp_alpha = longint'(val[14:0]);
            hfi_pkg::REG_DEMOD_ALPHA:    dm_alpha = longint'(val[14:0]);
            hfi_pkg::REG_MIN_RESPONSE:   min_resp = longint'(val[14:0]);
            hfi_pkg::REG_DEMOD_GAIN:     gain     = longint'(val);
            default: ;
        endcase
    endfunction

    function automatic plan_row_t wr(input hfi_pkg::cfg_idx_t idx, input logic [15:0] val);
        plan_row_t r;
        r = '{ROW_WRITE, idx, val, 1'b0, '0};
        return r;
    endfunction

    function automatic plan_row_t smp(input logic [15:0] cur);
        plan_row_t r;
        r = '{ROW_SAMPLE, REG_SPARE_A, cur, 1'b0, '0};
        return r;
    endfunction

    function automatic plan_row_t smp_typed(input logic [15:0] cur, input estimate_t want);
        plan_row_t r;
        r = '{ROW_SAMPLE, REG_SPARE_A, cur, 1'b1, want};
        return r;
    endfunction

    function automatic logic [15:0] pick_current();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2, 3:    v = 16'($urandom_range(0, 511)) - 16'd256;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_reg_value();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'h0000;
            1:       v = 16'h0001;
            2:       v = 16'h7FFF;
            3:       v = 16'hFFFF;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // stop sending and wait for every pending word
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (estimate_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input hfi_pkg::cfg_idx_t idx, input logic [15:0] val);
        if (!cfg_open) begin
            drain_results();
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_open  = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, val);
        writes++;
    endtask

    task automatic send_sample(input logic [15:0] cur, input bit typed, input estimate_t want);
        estimate_t e;
        if (cfg_open) begin
            cfg_valid <= 1'b0;
            cfg_open  = 1'b0;
        end
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cur;
        do @(posedge aclk); while (!s_tready);
        e = demodulate(cur);
        estimate_q.push_back(typed ? want : e);
        samples++;
    endtask

    // receiver back-pressure in bursts of random length, none started in the quiet phase
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 2);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        estimate_t e;
        if (aresetn && m_tvalid && m_tready) begin
            results++;
            if (estimate_q.size() == 0) begin
                $error("result word with no estimate pending");
                errors++;
            end else begin
                e = estimate_q.pop_front();
                if (m_tdata[15:0] !== e.injection) begin
                    $error("injection_d: expected %0d, got %0d",
                           $signed(e.injection), $signed(m_tdata[15:0]));
                    errors++;
                end
                if (m_tdata[31:16] !== e.pos_error) begin
                    $error("position_error: expected %0d, got %0d",
                           $signed(e.pos_error), $signed(m_tdata[31:16]));
                    errors++;
                end
                if (m_tdata[46:32] !== e.response) begin
                    $error("response: expected %0d, got %0d", e.response, m_tdata[46:32]);
                    errors++;
                end
                if (m_tdata[47] !== 1'b0) begin
                    $error("tdata pad: expected 0, got %b", m_tdata[47]);
                    errors++;
                end
                if (m_tuser !== e.est_valid) begin
                    $error("estimate_valid: expected %b, got %b", e.est_valid, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        plan_row_t plan[$];
        int        n;
        plan.push_back(smp_typed(16'h0000, '{16'd3276, 16'd0, 15'd0, 1'b0}));
        // zero amplitude and zero gain: everything stays at zero
        plan.push_back(wr(hfi_pkg::REG_INJ_AMPLITUDE, 16'h0000));
        plan.push_back(wr(hfi_pkg::REG_DEMOD_GAIN, 16'h0000));
        plan.push_back(smp_typed(16'h7FFF, '0));
        plan.push_back(smp_typed(16'h8000, '0));
        plan.push_back(smp_typed(16'h0001, '0));
        // top bit of the 15-bit registers must be dropped
        plan.push_back(wr(hfi_pkg::REG_INJ_AMPLITUDE, 16'hFFFF));
        plan.push_back(wr(hfi_pkg::REG_DEMOD_GAIN, 16'hFFFF));
        plan.push_back(wr(hfi_pkg::REG_DEMOD_ALPHA, 16'h7FFF));
        plan.push_back(wr(hfi_pkg::REG_HIGHPASS_ALPHA, 16'h7FFF));
        plan.push_back(wr(hfi_pkg::REG_PHASE_STEP, 16'h0000));
        plan.push_back(wr(hfi_pkg::REG_MIN_RESPONSE, 16'h8001));
        // carrier held still, drive the low-pass to its most negative value
        plan.push_back(smp(16'h7FFF));
        plan.push_back(smp(16'h8000));
        plan.push_back(smp(16'h8000));
        plan.push_back(smp(16'h8000));
        plan.push_back(smp(16'h8000));
        plan.push_back(wr(hfi_pkg::REG_PHASE_STEP, 16'hFFFF));
        plan.push_back(wr(REG_SPARE_A, 16'hFFFF));
        plan.push_back(wr(REG_SPARE_B, 16'h0000));
        plan.push_back(wr(hfi_pkg::REG_MIN_RESPONSE, 16'h7FFF));
        plan.push_back(smp(16'h0000));
        plan.push_back(smp(16'h7FFF));
        plan.push_back(wr(hfi_pkg::REG_PHASE_STEP, 16'h4000));
        plan.push_back(smp(16'h8000));
        plan.push_back(smp(16'h5555));
        plan.push_back(smp(16'hAAAA));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                write_reg(plan[i].idx, plan[i].value);
            end else begin
                send_sample(plan[i].value, plan[i].typed, plan[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            quiet = (p == PHASES - 1);
            n = $urandom_range(1, 6);
            repeat (n) begin
                write_reg(hfi_pkg::cfg_idx_t'($urandom_range(0, 7)), pick_reg_value());
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 3 && k == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                send_sample(pick_current(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (estimate_q.size() != 0) begin
            $error("%0d estimates never arrived", estimate_q.size());
            errors++;
        end
        $display("Ran %0d directed rows and %0d random phases with %0d register writes,",
                 plan.size(), PHASES, writes);
        $display("%0d current samples sent and %0d result words checked.", samples, results);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/hfi_pkg.sv
hw/rtl/hfi_cfg.sv
hw/rtl/hfi_useq.sv
hw/rtl/hfi_dpath.sv
hw/rtl/hfi_injection_demodulator_top.sv
hw/rtl/hfi_checker.sv
verif/tb_hfi_injection_demodulator_top.sv
